@@ rtl/rpdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Remote pulse distance transmitter package
// Shared codes, field widths and timing constants for the transmitter.
// ----------------------------------------------------------------------------
package rpdt_pkg;

    localparam int BITS_PER_FRAME = 17;
    localparam int BIT_IDX_W      = 5;
    localparam int TICK_W         = 20;
    localparam int UNIT_W         = 16;
    localparam int ADDR_W         = 7;
    localparam int CODE_W         = 7;
    localparam int REP_W          = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 20;

    // Header lengths in protocol units, and the low length of a one bit.
    localparam int HDR_HIGH_UNITS = 16;
    localparam int HDR_LOW_UNITS  = 8;
    localparam int ONE_LOW_UNITS  = 3;
    localparam int MAX_FRAMES     = 4;

    localparam logic [UNIT_W-1:0]     UNIT_RESET   = 16'd537;
    localparam logic [TICK_W-1:0]     GAP_RESET    = 20'd20000;
    localparam logic [ADDR_W-1:0]     ADDR_RESET   = 7'd71;
    localparam logic [REP_W-1:0]      REPEAT_RESET = 3'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_FRAMES = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNIT_TICKS   = 2'd0,
        REG_GAP_TICKS    = 2'd1,
        REG_DEVICE_ADDR  = 2'd2,
        REG_REPEAT_COUNT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HDR_LOW1 = 3'd1,
        PH_HDR_HIGH = 3'd2,
        PH_HDR_LOW2 = 3'd3,
        PH_BIT_HIGH = 3'd4,
        PH_BIT_LOW  = 3'd5,
        PH_GAP      = 3'd6
    } phase_t;

endpackage

@@ rtl/rpdt_if.sv @@
// ----------------------------------------------------------------------------
// Remote pulse distance transmitter channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface rpdt_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic [rpdt_pkg::CODE_W-1:0]  command_code;

    modport source (output valid, output cmd, output command_code, input ready);
    modport sink   (input valid, input cmd, input command_code, output ready);
endinterface

interface rpdt_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic rejected;
    logic sequence_done;

    modport source (output valid, output pin_level, output busy_res,
                    output rejected, output sequence_done, input ready);
    modport sink   (input valid, input pin_level, input busy_res,
                    input rejected, input sequence_done, output ready);
endinterface

interface rpdt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rpdt_pkg::CFG_IDX_W-1:0]   index;
    logic [rpdt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/remote_pulse_distance_transmitter_unit.sv @@
// ----------------------------------------------------------------------------
// Remote pulse distance transmitter
// Sequences header and command frames onto one line, one tick per request.
// ----------------------------------------------------------------------------
// Results are registered; the sequencer state updates in a single pass.
// Throughput: one request per cycle unless an untaken result stalls req.ready.
// The output register takes a new result while the previous one is being taken.
// Reset (rst_n, asynchronous, active low) sets the sequencer idle with the line
// low and loads the timing, address and repeat registers with their default values.
module remote_pulse_distance_transmitter_unit (
    input  logic        clk,
    input  logic        rst_n,
    rpdt_req_if.sink    req,
    rpdt_res_if.source  res,
    rpdt_cfg_if.sink    cfg
);

    // Configuration registers
    logic [rpdt_pkg::UNIT_W-1:0] unit_ticks_reg;
    logic [rpdt_pkg::TICK_W-1:0] gap_ticks_reg;
    logic [rpdt_pkg::ADDR_W-1:0] device_address_reg;
    logic [rpdt_pkg::REP_W-1:0]  repeat_count_reg;

    // Sequencer state
    rpdt_pkg::phase_t                       phase_reg, phase_next;
    logic [rpdt_pkg::BIT_IDX_W-1:0]         bit_index_reg, bit_index_next;
    logic [rpdt_pkg::BITS_PER_FRAME-1:0]    frame_bits_reg, frame_bits_next;
    logic [rpdt_pkg::TICK_W-1:0]            tick_count_reg, tick_count_next;
    logic [rpdt_pkg::REP_W-1:0]             frames_left_reg, frames_left_next;
    logic                                   line_level_reg, line_level_next;

    // Result register
    logic res_valid_reg;
    logic pin_level_reg;
    logic busy_reg;
    logic rejected_reg, rejected_next;
    logic done_reg, done_next;

    logic                          req_accept;
    logic                          busy;
    logic                          request;
    logic                          enter;
    rpdt_pkg::phase_t              enter_phase;
    logic [rpdt_pkg::TICK_W-1:0]   tick_keep;
    logic [rpdt_pkg::TICK_W-1:0]   tick_dec;
    logic [rpdt_pkg::REP_W-1:0]    frames_dec;
    logic [rpdt_pkg::REP_W-1:0]    frames_init;
    logic [rpdt_pkg::BIT_IDX_W-1:0] bit_inc;
    logic [rpdt_pkg::UNIT_W-1:0]   unit_eff;
    logic [rpdt_pkg::TICK_W-1:0]   unit_wide;
    logic                          cur_bit;

    assign cfg.ready  = 1'b1;
    assign req.ready  = !res_valid_reg || res.ready;
    assign req_accept = req.valid && req.ready;

    assign res.valid         = res_valid_reg;
    assign res.pin_level     = pin_level_reg;
    assign res.busy_res      = busy_reg;
    assign res.rejected      = rejected_reg;
    assign res.sequence_done = done_reg;

    assign busy    = (phase_reg != rpdt_pkg::PH_IDLE);
    assign request = (req.cmd == rpdt_pkg::CMD_HEADER) || (req.cmd == rpdt_pkg::CMD_FRAMES);

    assign unit_eff  = (unit_ticks_reg == '0) ? rpdt_pkg::UNIT_W'(1) : unit_ticks_reg;
    assign unit_wide = rpdt_pkg::TICK_W'(unit_eff);
    assign tick_dec  = tick_count_reg - rpdt_pkg::TICK_W'(tick_count_reg != '0);
    assign frames_dec = frames_left_reg - rpdt_pkg::REP_W'(frames_left_reg != '0);
    assign bit_inc   = bit_index_reg + rpdt_pkg::BIT_IDX_W'(1);

    always_comb
    begin
        if (repeat_count_reg == '0)
            frames_init = rpdt_pkg::REP_W'(1);
        else if (repeat_count_reg > rpdt_pkg::REP_W'(rpdt_pkg::MAX_FRAMES))
            frames_init = rpdt_pkg::REP_W'(rpdt_pkg::MAX_FRAMES);
        else
            frames_init = repeat_count_reg;
    end

    // Decide which segment comes next and how the frame bookkeeping moves.
    always_comb
    begin
        bit_index_next   = bit_index_reg;
        frame_bits_next  = frame_bits_reg;
        frames_left_next = frames_left_reg;
        tick_keep        = tick_count_reg;
        rejected_next    = 1'b0;
        done_next        = 1'b0;
        enter            = 1'b0;
        enter_phase      = rpdt_pkg::PH_IDLE;

        if (request && !busy)
        begin
            enter = 1'b1;
            if (req.cmd == rpdt_pkg::CMD_HEADER)
            begin
                enter_phase = rpdt_pkg::PH_HDR_LOW1;
            end
            else
            begin
                enter_phase      = rpdt_pkg::PH_BIT_HIGH;
                frames_left_next = frames_init;
                frame_bits_next  = {2'b11, req.command_code, device_address_reg, 1'b1};
                bit_index_next   = '0;
            end
        end
        else if (busy)
        begin
            rejected_next = request;
            if (tick_dec != '0)
            begin
                tick_keep = tick_dec;
            end
            else
            begin
                enter = 1'b1;
                case (phase_reg)
                    rpdt_pkg::PH_HDR_LOW1: enter_phase = rpdt_pkg::PH_HDR_HIGH;
                    rpdt_pkg::PH_HDR_HIGH: enter_phase = rpdt_pkg::PH_HDR_LOW2;
                    rpdt_pkg::PH_BIT_HIGH: enter_phase = rpdt_pkg::PH_BIT_LOW;
                    rpdt_pkg::PH_BIT_LOW:
                    begin
                        bit_index_next = bit_inc;
                        if (bit_inc < rpdt_pkg::BIT_IDX_W'(rpdt_pkg::BITS_PER_FRAME))
                            enter_phase = rpdt_pkg::PH_BIT_HIGH;
                        else
                            enter_phase = rpdt_pkg::PH_GAP;
                    end
                    rpdt_pkg::PH_GAP:
                    begin
                        frames_left_next = frames_dec;
                        if (frames_dec != '0)
                        begin
                            bit_index_next = '0;
                            enter_phase    = rpdt_pkg::PH_BIT_HIGH;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // A bit index past the frame never reaches the low segment; read it as zero.
    assign cur_bit = (bit_index_next < rpdt_pkg::BIT_IDX_W'(rpdt_pkg::BITS_PER_FRAME))
                   ? frame_bits_next[bit_index_next] : 1'b0;

    // Load the length and line level of the segment being entered.
    always_comb
    begin
        phase_next      = phase_reg;
        line_level_next = line_level_reg;
        tick_count_next = tick_keep;
        if (enter)
        begin
            phase_next = enter_phase;
            unique case (enter_phase)
                rpdt_pkg::PH_HDR_LOW1:
                begin
                    tick_count_next = unit_wide;
                    line_level_next = 1'b0;
                end
                rpdt_pkg::PH_HDR_HIGH:
                begin
                    tick_count_next = rpdt_pkg::TICK_W'(unit_wide * rpdt_pkg::HDR_HIGH_UNITS);
                    line_level_next = 1'b1;
                end
                rpdt_pkg::PH_HDR_LOW2:
                begin
                    tick_count_next = rpdt_pkg::TICK_W'(unit_wide * rpdt_pkg::HDR_LOW_UNITS);
                    line_level_next = 1'b0;
                end
                rpdt_pkg::PH_BIT_HIGH:
                begin
                    tick_count_next = unit_wide;
                    line_level_next = 1'b1;
                end
                rpdt_pkg::PH_BIT_LOW:
                begin
                    tick_count_next = cur_bit
                        ? rpdt_pkg::TICK_W'(unit_wide * rpdt_pkg::ONE_LOW_UNITS) : unit_wide;
                    line_level_next = 1'b0;
                end
                rpdt_pkg::PH_GAP:
                begin
                    tick_count_next = (gap_ticks_reg == '0)
                                    ? rpdt_pkg::TICK_W'(1) : gap_ticks_reg;
                    line_level_next = 1'b0;
                end
                default:
                begin
                    phase_next      = rpdt_pkg::PH_IDLE;
                    tick_count_next = '0;
                    line_level_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg     <= rpdt_pkg::UNIT_RESET;
            gap_ticks_reg      <= rpdt_pkg::GAP_RESET;
            device_address_reg <= rpdt_pkg::ADDR_RESET;
            repeat_count_reg   <= rpdt_pkg::REPEAT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rpdt_pkg::REG_UNIT_TICKS:   unit_ticks_reg     <= cfg.data[rpdt_pkg::UNIT_W-1:0];
                rpdt_pkg::REG_GAP_TICKS:    gap_ticks_reg      <= cfg.data[rpdt_pkg::TICK_W-1:0];
                rpdt_pkg::REG_DEVICE_ADDR:  device_address_reg <= cfg.data[rpdt_pkg::ADDR_W-1:0];
                rpdt_pkg::REG_REPEAT_COUNT: repeat_count_reg   <= cfg.data[rpdt_pkg::REP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= rpdt_pkg::PH_IDLE;
            bit_index_reg   <= '0;
            frame_bits_reg  <= '0;
            tick_count_reg  <= '0;
            frames_left_reg <= '0;
            line_level_reg  <= 1'b0;
        end
        else if (req_accept)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            frame_bits_reg  <= frame_bits_next;
            tick_count_reg  <= tick_count_next;
            frames_left_reg <= frames_left_next;
            line_level_reg  <= line_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (req_accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            pin_level_reg <= line_level_next;
            busy_reg      <= (phase_next != rpdt_pkg::PH_IDLE);
            rejected_reg  <= rejected_next;
            done_reg      <= done_next;
        end
    end

    // The line is only driven high while a sequence is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && pin_level_reg |-> busy_reg)
        else $error("line high in a result that is not busy");

    // A finished request leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && done_reg |-> !busy_reg)
        else $error("sequence done reported while still busy");

    // The idle sequencer holds the line low with no segment counting.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rpdt_pkg::PH_IDLE |-> !line_level_reg && tick_count_reg == '0)
        else $error("idle sequencer with line or counter active");

    // A request accepted while busy is flagged on its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && busy && request |=> res_valid_reg && rejected_reg)
        else $error("request during a sequence not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        frames_left_reg <= rpdt_pkg::REP_W'(rpdt_pkg::MAX_FRAMES))
        else $error("frame counter beyond the repeat limit");

endmodule
